// ===== src/hpac_pkg.sv =====
// ----------------------------------------------------------------------------
// hpac_pkg
// Shared types, widths and codes for the handle pool allocator / compactor.
// ----------------------------------------------------------------------------
package hpac_pkg;

  localparam int SLOTS    = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int OPCODE_W = 2;
  localparam int HANDLE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_FW = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_COMPACT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_HELD    = 2'd2,
    ST_NOT_PENDING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_RELEASE,
    S_CP_SCAN,
    S_CP_RD_HI,
    S_CP_WR_LO,
    S_CP_WR_HI,
    S_RESP
  } state_t;

  // one read and one write port request toward a table memory
  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    slot_t raddr;
  } mem_req_t;

endpackage

// ===== src/hpac_req_if.sv =====
// ----------------------------------------------------------------------------
// hpac_req_if
// Request channel: opcode and handle with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpac_req_if;
  logic                          valid;
  logic                          ready;
  logic [hpac_pkg::OPCODE_W-1:0] opcode;
  logic [hpac_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, output opcode, output handle, input ready);
  modport sink (input valid, input opcode, input handle, output ready);
endinterface

// ===== src/hpac_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hpac_rsp_if
// Response channel: one result per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpac_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hpac_pkg::STATUS_W-1:0] status;
  logic [hpac_pkg::HANDLE_W-1:0] granted_handle;
  logic [hpac_pkg::HANDLE_W-1:0] slot_index;
  logic [hpac_pkg::COUNT_FW-1:0] used_count;
  logic [hpac_pkg::COUNT_FW-1:0] moves_done;

  modport source (output valid, output status, output granted_handle, output slot_index,
                  output used_count, output moves_done, input ready);
  modport sink (input valid, input status, input granted_handle, input slot_index,
                input used_count, input moves_done, output ready);
endinterface

// ===== src/handle_pool_allocator_compactor_top.sv =====
// ----------------------------------------------------------------------------
// handle_pool_allocator_compactor_top
// Fixed pool of entries with stable handles, a free stack and compaction.
// ----------------------------------------------------------------------------
// usage:
//   req carries opcode (create, release, compact) and the handle to release;
//   rsp returns one result per request: status, granted or released handle,
//   its slot, the held count after the operation and the moves of a compact.
//   create and release do one table read of the handle-to-slot memory,
//   then the update. a compact scans for a swap before each move and once
//   more at the end; each move is two reads and two writes on the
//   slot-owner memory. full pool, nothing pending and the spare opcode
//   answer straight from idle, with no table read.
//   one request is in flight at a time; req.ready is high only while idle.
//   the result sits in an output register; if rsp is stalled the finished
//   result is parked and req.ready stays low until rsp takes a transfer.
//   reset is synchronous; the tables come up with every slot unused and each
//   handle in its own slot at once, with no clearing pass.
// ----------------------------------------------------------------------------
module handle_pool_allocator_compactor_top (
  input logic        clk,
  input logic        rst,
  hpac_req_if.sink   req,
  hpac_rsp_if.source rsp
);
  import hpac_pkg::*;

  mem_req_t owner_req;
  mem_req_t hslot_req;
  slot_t    owner_rdata;
  slot_t    hslot_rdata;

  hpac_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .owner_req   (owner_req),
    .owner_rdata (owner_rdata),
    .hslot_req   (hslot_req),
    .hslot_rdata (hslot_rdata)
  );

  // slot -> owning handle
  hpac_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_W)
  ) u_owner_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (owner_req.we),
    .waddr (owner_req.waddr),
    .wdata (owner_req.wdata),
    .raddr (owner_req.raddr),
    .rdata (owner_rdata)
  );

  // handle -> slot holding its entry
  hpac_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_W)
  ) u_hslot_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (hslot_req.we),
    .waddr (hslot_req.waddr),
    .wdata (hslot_req.wdata),
    .raddr (hslot_req.raddr),
    .rdata (hslot_rdata)
  );

endmodule

// ===== src/hpac_ram.sv =====
// ----------------------------------------------------------------------------
// hpac_ram
// Single write / single read synchronous RAM; read data comes the cycle after the address.
// Entries never written since reset read back as their own address.
// ----------------------------------------------------------------------------
module hpac_ram #(
  parameter  int DEPTH = 8,
  parameter  int WIDTH = 3,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rdata_q;
  logic             written_q;
  logic [AW-1:0]    raddr_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      written_q <= written[raddr];
    end
  end

  // identity contents until an entry is first written
  assign rdata = written_q ? rdata_q : WIDTH'(raddr_q);

endmodule

// ===== src/hpac_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpac_ctrl
// Sequencer for create / release / compact: used-slot map, free stack,
// counters, table read-modify-write and the result register.
// ----------------------------------------------------------------------------
module hpac_ctrl (
  input  logic               clk,
  input  logic               rst,
  hpac_req_if.sink           req,
  hpac_rsp_if.source         rsp,
  output hpac_pkg::mem_req_t owner_req,
  input  hpac_pkg::slot_t    owner_rdata,
  output hpac_pkg::mem_req_t hslot_req,
  input  hpac_pkg::slot_t    hslot_rdata
);
  import hpac_pkg::*;

  state_t state, state_next;

  // an invalidated slot behaves exactly like an unused one, so one bit per slot
  logic [SLOTS-1:0] used, used_next;
  slot_t            free_stack [SLOTS];
  cnt_t             depth, depth_next;
  cnt_t             held, held_next;
  logic             pending, pending_next;
  logic             push;
  logic [HANDLE_W-1:0] cur_handle, cur_handle_next;
  slot_t            lo, lo_next, hi, hi_next;
  slot_t            owner_lo, owner_lo_next, owner_hi, owner_hi_next;
  cnt_t             moves, moves_next;

  logic                fin_valid;
  status_t             fin_status;
  logic [HANDLE_W-1:0] fin_handle;
  logic [HANDLE_W-1:0] fin_slot;
  logic [COUNT_FW-1:0] fin_moves;

  status_t             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [HANDLE_W-1:0] res_slot;
  logic [COUNT_FW-1:0] res_moves;

  logic                out_valid;
  status_t             out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic [HANDLE_W-1:0] out_slot;
  logic [COUNT_FW-1:0] out_used;
  logic [COUNT_FW-1:0] out_moves;
  logic                out_free;

  cnt_t  top_idx;
  slot_t free_top;
  logic  full;
  logic  h_in_range;
  logic  have_lo, have_hi, do_swap;
  slot_t scan_lo, scan_hi;

  assign top_idx    = depth - 1'b1;
  assign free_top   = free_stack[top_idx[SLOT_W-1:0]];
  assign full       = (depth == '0) || (held >= CNT_W'(SLOTS));
  assign h_in_range = 32'(req.handle) < SLOTS;
  assign out_free   = !out_valid || rsp.ready;

  // lowest hole and highest used slot
  always_comb begin
    have_lo = 1'b0;
    scan_lo = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        have_lo = 1'b1;
        scan_lo = SLOT_W'(i);
      end
    end
    have_hi = 1'b0;
    scan_hi = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used[i]) begin
        have_hi = 1'b1;
        scan_hi = SLOT_W'(i);
      end
    end
    do_swap = have_lo && have_hi && (scan_lo < scan_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    used_next       = used;
    depth_next      = depth;
    held_next       = held;
    pending_next    = pending;
    push            = 1'b0;
    cur_handle_next = cur_handle;
    lo_next         = lo;
    hi_next         = hi;
    owner_lo_next   = owner_lo;
    owner_hi_next   = owner_hi;
    moves_next      = moves;
    fin_valid       = 1'b0;
    fin_status      = ST_OK;
    fin_handle      = '0;
    fin_slot        = '0;
    fin_moves       = '0;
    owner_req       = '0;
    hslot_req       = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur_handle_next = req.handle;
          moves_next      = '0;
          case (opcode_t'(req.opcode))
            OP_CREATE: begin
              if (full) begin
                fin_valid  = 1'b1;
                fin_status = ST_FULL;
              end else begin
                hslot_req.raddr = free_top;
                cur_handle_next = HANDLE_W'(free_top);
                state_next      = S_CREATE;
              end
            end
            OP_RELEASE: begin
              if (!h_in_range) begin
                fin_valid  = 1'b1;
                fin_status = ST_NOT_HELD;
                fin_handle = req.handle;
              end else begin
                hslot_req.raddr = SLOT_W'(req.handle);
                state_next      = S_RELEASE;
              end
            end
            OP_COMPACT: begin
              if (!pending) begin
                fin_valid  = 1'b1;
                fin_status = ST_NOT_PENDING;
              end else begin
                state_next = S_CP_SCAN;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_CREATE: begin
        depth_next             = depth - 1'b1;
        held_next              = held + 1'b1;
        used_next[hslot_rdata] = 1'b1;
        fin_valid              = 1'b1;
        fin_handle             = cur_handle;
        fin_slot               = HANDLE_W'(hslot_rdata);
      end
      S_RELEASE: begin
        fin_valid  = 1'b1;
        fin_handle = cur_handle;
        if (!used[hslot_rdata]) begin
          fin_status = ST_NOT_HELD;
        end else begin
          used_next[hslot_rdata] = 1'b0;
          if (depth < CNT_W'(SLOTS)) begin
            push       = 1'b1;
            depth_next = depth + 1'b1;
          end
          if (held != '0) begin
            held_next = held - 1'b1;
          end
          pending_next = 1'b1;
          fin_slot     = HANDLE_W'(hslot_rdata);
        end
      end
      S_CP_SCAN: begin
        if (do_swap) begin
          lo_next         = scan_lo;
          hi_next         = scan_hi;
          owner_req.raddr = scan_lo;
          state_next      = S_CP_RD_HI;
        end else begin
          pending_next = 1'b0;
          fin_valid    = 1'b1;
          fin_moves    = COUNT_FW'(moves);
        end
      end
      S_CP_RD_HI: begin
        owner_req.raddr = hi;
        owner_lo_next   = owner_rdata;
        state_next      = S_CP_WR_LO;
      end
      S_CP_WR_LO: begin
        // entry at hi moves down into the hole at lo
        owner_hi_next   = owner_rdata;
        owner_req.we    = 1'b1;
        owner_req.waddr = lo;
        owner_req.wdata = owner_rdata;
        hslot_req.we    = 1'b1;
        hslot_req.waddr = owner_rdata;
        hslot_req.wdata = lo;
        state_next      = S_CP_WR_HI;
      end
      S_CP_WR_HI: begin
        // the hole's owner goes up to hi
        owner_req.we    = 1'b1;
        owner_req.waddr = hi;
        owner_req.wdata = owner_lo;
        hslot_req.we    = 1'b1;
        hslot_req.waddr = owner_lo;
        hslot_req.wdata = hi;
        used_next[lo]   = 1'b1;
        used_next[hi]   = 1'b0;
        moves_next      = moves + 1'b1;
        state_next      = S_CP_SCAN;
      end
      S_RESP: begin
        fin_valid  = 1'b1;
        fin_status = res_status;
        fin_handle = res_handle;
        fin_slot   = res_slot;
        fin_moves  = res_moves;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin_valid) begin
      state_next = out_free ? S_IDLE : S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      depth   <= CNT_W'(SLOTS);
      held    <= '0;
      pending <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        free_stack[i] <= SLOT_W'(SLOTS - 1 - i);
      end
    end else begin
      used    <= used_next;
      depth   <= depth_next;
      held    <= held_next;
      pending <= pending_next;
      if (push) begin
        free_stack[depth[SLOT_W-1:0]] <= SLOT_W'(cur_handle);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_handle <= cur_handle_next;
    lo         <= lo_next;
    hi         <= hi_next;
    owner_lo   <= owner_lo_next;
    owner_hi   <= owner_hi_next;
    moves      <= moves_next;
    if (fin_valid && !out_free) begin
      res_status <= fin_status;
      res_handle <= fin_handle;
      res_slot   <= fin_slot;
      res_moves  <= fin_moves;
    end
    if (fin_valid && out_free) begin
      out_status <= fin_status;
      out_handle <= fin_handle;
      out_slot   <= fin_slot;
      out_used   <= COUNT_FW'(held_next);
      out_moves  <= fin_moves;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_handle = out_handle;
  assign rsp.slot_index     = out_slot;
  assign rsp.used_count     = out_used;
  assign rsp.moves_done     = out_moves;

`ifndef NO_ASSERTIONS
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    (32'(held) + 32'(depth)) == SLOTS)
    else $error("held and free counts do not add up to the pool size");

  a_used_map: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == 32'(held))
    else $error("used slot map disagrees with held count");

  a_swap_owners: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_WR_HI) |-> (owner_hi != owner_lo))
    else $error("compaction swap reads the same owner twice");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_RD_HI) |-> (lo < hi) && !used[lo] && used[hi])
    else $error("compaction moves an entry outward or into a used slot");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives create, release and compact requests into the handle pool and checks
// every response against a cycle-free model of the pool, with random stalls
// on both channels and one long response stall that backs up the requests.
// ----------------------------------------------------------------------------
module testbench;
  import hpac_pkg::*;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef enum logic [1:0] {
    SLOT_UNUSED      = 2'd0,
    SLOT_USED        = 2'd1,
    SLOT_INVALIDATED = 2'd2
  } slot_kind_t;

  typedef struct packed {
    status_t             status;
    handle_t             handle;
    handle_t             slot;
    logic [COUNT_FW-1:0] used;
    logic [COUNT_FW-1:0] moves;
  } pool_result_t;

  class pool_tracker;
    slot_kind_t   kind [SLOTS];
    slot_t        owner [SLOTS];
    slot_t        home_slot [SLOTS];
    slot_t        free_stack [SLOTS];
    int           free_depth;
    int           held_count;
    bit           compact_pending;
    pool_result_t pending_results [$];
    int           errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        kind[i] = SLOT_UNUSED;
        owner[i] = slot_t'(i);
        home_slot[i] = slot_t'(i);
        free_stack[i] = slot_t'(SLOTS - 1 - i);
      end
      free_depth = SLOTS;
      held_count = 0;
      compact_pending = 0;
      errors = 0;
    endfunction

    function handle_t pick_held();
      handle_t held [$];
      for (int h = 0; h < SLOTS; h++)
        if (kind[home_slot[h]] == SLOT_USED) held.push_back(handle_t'(h));
      if (held.size() == 0) return handle_t'($urandom);
      return held[$urandom_range(held.size() - 1)];
    endfunction

    // model update for one request transfer, result queued in order
    function void note_request(opcode_t op, handle_t h);
      pool_result_t r;
      slot_t        s;
      slot_t        nh;
      slot_kind_t   k;
      slot_t        o;
      int           lo;
      int           hi;
      int           moves;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_CREATE: begin
          if (free_depth == 0 || held_count >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            free_depth--;
            nh = free_stack[free_depth];
            s = home_slot[nh];
            kind[s] = SLOT_USED;
            held_count++;
            r.handle = handle_t'(nh);
            r.slot = handle_t'(s);
          end
        end
        OP_RELEASE: begin
          r.handle = h;
          if (int'(h) >= SLOTS || kind[home_slot[h]] != SLOT_USED) begin
            r.status = ST_NOT_HELD;
          end else begin
            s = home_slot[h];
            kind[s] = SLOT_INVALIDATED;
            if (free_depth < SLOTS) begin
              free_stack[free_depth] = slot_t'(h);
              free_depth++;
            end
            if (held_count > 0) held_count--;
            compact_pending = 1;
            r.slot = handle_t'(s);
          end
        end
        OP_COMPACT: begin
          if (!compact_pending) begin
            r.status = ST_NOT_PENDING;
          end else begin
            lo = 0;
            hi = SLOTS - 1;
            moves = 0;
            forever begin
              while (lo < SLOTS && kind[lo] == SLOT_USED) lo++;
              while (hi > 0 && kind[hi] != SLOT_USED) hi--;
              if (lo >= SLOTS || lo >= hi || kind[hi] != SLOT_USED) break;
              k = kind[lo];
              o = owner[lo];
              kind[lo] = kind[hi];
              owner[lo] = owner[hi];
              kind[hi] = k;
              owner[hi] = o;
              home_slot[owner[lo]] = slot_t'(lo);
              home_slot[owner[hi]] = slot_t'(hi);
              moves++;
            end
            // invalidated slots become unused once the pool is packed
            for (int i = 0; i < SLOTS; i++)
              if (kind[i] == SLOT_INVALIDATED) kind[i] = SLOT_UNUSED;
            compact_pending = 0;
            r.moves = moves[COUNT_FW-1:0];
          end
        end
        default: begin
        end
      endcase
      r.used = held_count[COUNT_FW-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_response(pool_result_t got);
      pool_result_t exp;
      bit           bad;
      if (pending_results.size() == 0) begin
        if (errors < 10) $display("unexpected response: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      bad = (got.status !== exp.status) || (got.handle !== exp.handle) ||
            (got.slot !== exp.slot) || (got.used !== exp.used) ||
            (got.moves !== exp.moves);
      if (bad) begin
        if (errors < 10)
          $display("response mismatch: exp st=%0d h=%0d slot=%0d used=%0d moves=%0d,",
                   exp.status, exp.handle, exp.slot, exp.used, exp.moves,
                   " got st=%0d h=%0d slot=%0d used=%0d moves=%0d",
                   got.status, got.handle, got.slot, got.used, got.moves);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_req;
  int          cycle_count;
  pool_tracker pool;

  hpac_req_if req_ch ();
  hpac_rsp_if rsp_ch ();

  handle_pool_allocator_compactor_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      pool.check_response({status_t'(rsp_ch.status), rsp_ch.granted_handle,
                           rsp_ch.slot_index, rsp_ch.used_count, rsp_ch.moves_done});
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_req(opcode_t op, handle_t h);
    // idle cycles carry junk payload with valid low
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.opcode <= 2'($urandom);
      req_ch.handle <= handle_t'($urandom);
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.handle <= h;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pool.note_request(op, h);
  endtask

  task automatic run_directed();
    send_req(OP_COMPACT, 3'd0);
    send_req(OP_RELEASE, 3'd7);
    send_req(OP_NONE, 3'd5);
    repeat (SLOTS) send_req(OP_CREATE, 3'd2);
    send_req(OP_CREATE, 3'd0);
    send_req(OP_RELEASE, 3'd0);
    send_req(OP_RELEASE, 3'd5);
    // already invalidated, not held any more
    send_req(OP_RELEASE, 3'd0);
    send_req(OP_COMPACT, 3'd7);
    send_req(OP_RELEASE, 3'd7);
    send_req(OP_CREATE, 3'd0);
    send_req(OP_COMPACT, 3'd0);
    for (int h = 0; h < SLOTS; h++) send_req(OP_RELEASE, handle_t'(h));
    send_req(OP_COMPACT, 3'd0);
  endtask

  task automatic run_random(int count);
    bit filling;
    int r;
    filling = 1;
    for (int n = 0; n < count; n++) begin
      if (pool.held_count >= SLOTS) filling = 0;
      else if (pool.held_count == 0) filling = 1;
      r = $urandom_range(99);
      if (r < 4) send_req(OP_NONE, handle_t'($urandom));
      else if (r < 9) send_req(OP_RELEASE, handle_t'($urandom));
      else if (r < 12) send_req(OP_COMPACT, handle_t'($urandom));
      else if (r < 24 && pool.compact_pending) send_req(OP_COMPACT, handle_t'($urandom));
      else if ($urandom_range(99) < (filling ? 75 : 25)) send_req(OP_CREATE, handle_t'($urandom));
      else send_req(OP_RELEASE, pool.pick_held());
    end
  endtask

  initial begin
    pool = new();
    hold_off_req = 0;
    send_idle_pct = 28;
    recv_idle_pct = 81;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_CREATE;
    req_ch.handle <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(PHASE_ITEMS);
    send_idle_pct = 81;
    recv_idle_pct = 28;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1;
    run_random(PHASE_ITEMS);
    req_ch.valid <= 1'b0;
    while (pool.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pool.errors == 0 && pool.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
